@@ hdl/sdmd_pkg.sv @@
// shared types and constants for the sigma-delta motion detector
// no dependencies
package sdmd_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned FRAME_W = 18;
  localparam int unsigned AMP_W   = 4;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned ODATA_W = 3 * PIX_W;

  typedef logic [PIX_W-1:0] pix_t;

  localparam logic [IDX_W-1:0] REG_FRAME_PIXELS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMPLIFICATION = 2'd1;
  localparam logic [IDX_W-1:0] REG_VMIN          = 2'd2;
  localparam logic [IDX_W-1:0] REG_VMAX          = 2'd3;

  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST  = 18'd76800;
  localparam logic [AMP_W-1:0]   AMPLIFICATION_RST = 4'd3;
  localparam pix_t               VMIN_RST          = 8'd1;
  localparam pix_t               VMAX_RST          = 8'd254;
  localparam pix_t               PIX_MAX           = 8'd255;

endpackage

@@ hdl/sigma_delta_motion_detect.sv @@
// sigma-delta motion detector top level: pixel store, update logic, output register
// depends on sdmd_pkg
//
// usage:
//   pixels enter in raster order on the s_axis channel, one per transaction;
//   tuser carries the first-frame flag that loads the stored background with
//   the pixel and the variance with vmin
//   one result per pixel leaves on m_axis: tdata holds difference, background
//   and variance, tuser the foreground flag, tlast marks the last frame pixel
//   an accepted pixel passes the stage 1 registers, then the output register;
//   one pixel per cycle is sustained while the receiver accepts, set by the
//   single read port and single write port of the background/variance memory;
//   a same-cycle read of the entry being written gets its new value by forwarding
//   the memory is undefined after reset and must be filled by a first frame;
//   reset clears the position counter and loads register defaults
//   when the receiver stalls the output register holds its result, the update
//   stage holds one more, and tready drops; nothing is lost
//   configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle
module sigma_delta_motion_detect #(
  parameter int unsigned MAX_PIXELS = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdmd_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [sdmd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sdmd_pkg::PIX_W-1:0]    s_axis_tdata,  // pixel
  input  logic                          s_axis_tuser,  // first_frame
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sdmd_pkg::ODATA_W-1:0]  m_axis_tdata,  // difference, background, variance
  output logic                          m_axis_tuser,  // foreground
  output logic                          m_axis_tlast   // frame_end
);
  import sdmd_pkg::*;

  localparam int unsigned PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned SW = (PW + 1 > FRAME_W) ? PW + 1 : FRAME_W;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_PIXELS);
  localparam int unsigned MW = 2 * PIX_W;
  localparam int unsigned TW = PIX_W + AMP_W;

  // configuration registers
  logic [FRAME_W-1:0] frame_pixels_q;
  logic [AMP_W-1:0]   amplification_q;
  pix_t               vmin_q, vmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q  <= FRAME_PIXELS_RST;
      amplification_q <= AMPLIFICATION_RST;
      vmin_q          <= VMIN_RST;
      vmax_q          <= VMAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_PIXELS:  frame_pixels_q  <= cfg_data_i[FRAME_W-1:0];
        REG_AMPLIFICATION: amplification_q <= cfg_data_i[AMP_W-1:0];
        REG_VMIN:          vmin_q          <= cfg_data_i[PIX_W-1:0];
        REG_VMAX:          vmax_q          <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // position counter
  logic [PW-1:0] pos_q, pos_d;
  logic [SW-1:0] size_eff, pos_inc;
  logic          fend_in;

  always_comb begin
    size_eff = SW'(frame_pixels_q);
    if (size_eff == '0 || size_eff > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end
    pos_inc = SW'(pos_q) + SW'(1);
    fend_in = (pos_inc >= size_eff);
    pos_d   = pos_q;
    if (in_acc) begin
      pos_d = fend_in ? '0 : pos_inc[PW-1:0];
    end
  end

  // stage 1 registers
  logic [PW-1:0] s1_addr_q;
  pix_t          s1_pix_q;
  logic          s1_first_q, s1_fend_q, s1_fwd_q;
  logic [MW-1:0] s1_fwd_data_q;
  logic [MW-1:0] mem_rdata_q;
  logic [MW-1:0] wr_data;

  logic [MW-1:0] mem [MAX_PIXELS];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_addr_q] <= wr_data;
    end
    if (in_acc) begin
      mem_rdata_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q     <= pos_q;
      s1_pix_q      <= s_axis_tdata;
      s1_first_q    <= s_axis_tuser;
      s1_fend_q     <= fend_in;
      s1_fwd_q      <= s1_adv && (s1_addr_q == pos_q);
      s1_fwd_data_q <= wr_data;
    end
  end

  // background and variance update
  pix_t          cur_bg, cur_var, new_bg, new_var, diff;
  logic [TW-1:0] target;
  logic          fg;

  always_comb begin
    {cur_var, cur_bg} = s1_fwd_q ? s1_fwd_data_q : mem_rdata_q;
    if (s1_first_q) begin
      new_bg  = s1_pix_q;
      diff    = '0;
      target  = '0;
      new_var = vmin_q;
    end else begin
      if (cur_bg < s1_pix_q) begin
        new_bg = cur_bg + 8'd1;
      end else if (cur_bg > s1_pix_q) begin
        new_bg = cur_bg - 8'd1;
      end else begin
        new_bg = cur_bg;
      end
      diff   = (s1_pix_q > new_bg) ? s1_pix_q - new_bg : new_bg - s1_pix_q;
      target = TW'(amplification_q) * TW'(diff);
      if (TW'(cur_var) < target) begin
        new_var = (cur_var == PIX_MAX) ? PIX_MAX : cur_var + 8'd1;
      end else if (TW'(cur_var) > target) begin
        new_var = cur_var - 8'd1;
      end else begin
        new_var = cur_var;
      end
      priority if (new_var < vmin_q) begin
        new_var = vmin_q;
      end else if (new_var > vmax_q) begin
        new_var = vmax_q;
      end
    end
    fg      = (diff >= new_var);
    wr_data = {new_var, new_bg};
  end

  // output register
  logic [ODATA_W-1:0] out_data_q;
  logic               out_fg_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {new_var, new_bg, diff};
      out_fg_q   <= fg;
      out_last_q <= s1_fend_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fg_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ bench/sdmd_checker.sv @@
// checker for the sigma-delta motion detector: tracks config writes, predicts each pixel result
// and compares it with the output stream
// depends on sdmd_pkg
module sdmd_checker #(
  parameter int unsigned MAX_PIXELS = 131072
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sdmd_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sdmd_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [sdmd_pkg::PIX_W-1:0]   s_axis_tdata,   // pixel
  input  logic                         s_axis_tuser,   // first_frame
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [sdmd_pkg::ODATA_W-1:0] m_axis_tdata,   // difference, background, variance
  input  logic                         m_axis_tuser,   // foreground
  input  logic                         m_axis_tlast,   // frame_end
  output int                           errors_o,
  output int                           pending_o
);
  import sdmd_pkg::*;

  typedef struct packed {
    logic foreground;
    pix_t difference;
    pix_t background;
    pix_t variance;
    logic frame_end;
  } pixel_outcome_t;

  pix_t                 bg_mem  [MAX_PIXELS];
  pix_t                 var_mem [MAX_PIXELS];
  int unsigned          px_pos;
  logic [FRAME_W-1:0]   frame_px;
  logic [AMP_W-1:0]     amp;
  pix_t                 vmin;
  pix_t                 vmax;
  pixel_outcome_t       outcomes_q [$];
  int                   errors  = 0;
  int                   pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic pix_t nudge(input pix_t cur, input int unsigned target);
    if (cur < target) return (cur == PIX_MAX) ? cur : cur + 8'd1;
    if (cur > target) return cur - 8'd1;
    return cur;
  endfunction

  function automatic pixel_outcome_t update_pixel(input pix_t pix, input logic first);
    pixel_outcome_t r;
    int unsigned    frame_len;
    pix_t           bgv;
    pix_t           dv;
    pix_t           vv;
    frame_len = (frame_px == '0 || frame_px > MAX_PIXELS) ? MAX_PIXELS : int'(frame_px);
    if (first) begin
      bgv = pix;
      dv  = '0;
      vv  = vmin;
    end else begin
      bgv = nudge(bg_mem[px_pos], pix);
      dv  = (pix > bgv) ? pix - bgv : bgv - pix;
      vv  = nudge(var_mem[px_pos], int'(amp) * int'(dv));
      if (vv < vmin) vv = vmin;
      else if (vv > vmax) vv = vmax;
    end
    bg_mem[px_pos]  = bgv;
    var_mem[px_pos] = vv;
    r.foreground = (dv >= vv);
    r.difference = dv;
    r.background = bgv;
    r.variance   = vv;
    r.frame_end  = (px_pos + 1 >= frame_len);
    px_pos = r.frame_end ? 0 : px_pos + 1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_outcome_t want;
    if (!rst_ni) begin
      px_pos   = 0;
      frame_px = FRAME_PIXELS_RST;
      amp      = AMPLIFICATION_RST;
      vmin     = VMIN_RST;
      vmax     = VMAX_RST;
      outcomes_q.delete();
      pending  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcomes_q.size() == 0) begin
          flag_mismatch("result with no pixel pending", 1, 0);
        end else begin
          want = outcomes_q.pop_front();
          if (m_axis_tuser !== want.foreground)
            flag_mismatch("foreground", m_axis_tuser, want.foreground);
          if (m_axis_tdata[7:0] !== want.difference)
            flag_mismatch("difference", m_axis_tdata[7:0], want.difference);
          if (m_axis_tdata[15:8] !== want.background)
            flag_mismatch("background", m_axis_tdata[15:8], want.background);
          if (m_axis_tdata[23:16] !== want.variance)
            flag_mismatch("variance", m_axis_tdata[23:16], want.variance);
          if (m_axis_tlast !== want.frame_end)
            flag_mismatch("frame_end", m_axis_tlast, want.frame_end);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcomes_q.push_back(update_pixel(s_axis_tdata, s_axis_tuser));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_PIXELS:  frame_px = cfg_data_i[FRAME_W-1:0];
          REG_AMPLIFICATION: amp      = cfg_data_i[AMP_W-1:0];
          REG_VMIN:          vmin     = cfg_data_i[PIX_W-1:0];
          REG_VMAX:          vmax     = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
      pending = outcomes_q.size();
    end
  end

endmodule

@@ bench/sigma_delta_motion_detect_tb.sv @@
// testbench top for the sigma-delta motion detector: clock, reset, config phases and pixel
// stimulus with random idling; verdict from the failure count of sdmd_checker
// depends on sdmd_pkg, sdmd_checker and sigma_delta_motion_detect
module sigma_delta_motion_detect_tb;
  import sdmd_pkg::*;

  localparam int unsigned MAX_PX       = 131072;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 56;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [PIX_W-1:0]   s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ODATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;
  int                 errors;
  int                 pending;

  int unsigned        src_idle  = 0;
  int unsigned        sink_stall = 0;
  int unsigned        cycles    = 0;
  int unsigned        stim_pos  = 0;
  int unsigned        stim_frame = FRAME_PIXELS_RST;
  bit                 written [MAX_PX];

  always #5 clk_i = ~clk_i;

  sigma_delta_motion_detect #(
    .MAX_PIXELS (MAX_PX)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sdmd_checker #(
    .MAX_PIXELS (MAX_PX)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready = rst_ni && ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value[CFG_W-1:0];
    if (idx == REG_FRAME_PIXELS) stim_frame = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_params(input int unsigned frame, input int unsigned a,
                            input int unsigned lo, input int unsigned hi);
    write_reg(REG_FRAME_PIXELS, frame);
    write_reg(REG_AMPLIFICATION, a);
    write_reg(REG_VMIN, lo);
    write_reg(REG_VMAX, hi);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // positions never written must start with a first-frame pixel
  task automatic feed(input pix_t pix, input logic first_req);
    int unsigned frame_len;
    logic        first;
    first = first_req || !written[stim_pos];
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pix;
    s_axis_tuser  = first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    written[stim_pos] = 1'b1;
    frame_len = (stim_frame == 0 || stim_frame > MAX_PX) ? MAX_PX : stim_frame;
    stim_pos  = (stim_pos + 1 >= frame_len) ? 0 : stim_pos + 1;
  endtask

  function automatic pix_t near(input int base);
    int v;
    v = base + int'($urandom_range(12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  initial begin
    int unsigned frame;
    int          base;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_params(4, 15, 0, 255);
    feed(8'd0, 1'b1);
    feed(8'd255, 1'b1);
    feed(8'd128, 1'b1);
    feed(8'd1, 1'b1);
    feed(8'd255, 1'b0);
    feed(8'd0, 1'b0);
    feed(8'd128, 1'b0);
    feed(8'd0, 1'b0);
    drain();

    // variance saturated at the top and asked to rise further
    write_reg(REG_VMIN, 255);
    feed(8'd7, 1'b1);
    feed(8'd200, 1'b1);
    feed(8'd30, 1'b1);
    feed(8'd90, 1'b1);
    drain();
    write_reg(REG_VMIN, 0);
    feed(8'd255, 1'b0);
    feed(8'd0, 1'b0);
    feed(8'd255, 1'b0);
    feed(8'd0, 1'b0);
    drain();

    // crossed clamp bounds
    set_params(4, 1, 200, 100);
    feed(8'd10, 1'b0);
    feed(8'd250, 1'b0);
    drain();

    // zero gain
    set_params(4, 0, 0, 255);
    feed(8'd60, 1'b0);
    feed(8'd60, 1'b0);
    drain();

    // frame size out of range, then shrunk below the position
    write_reg(REG_FRAME_PIXELS, 0);
    repeat (6) feed(pix_t'($urandom_range(255)), 1'b0);
    drain();
    write_reg(REG_FRAME_PIXELS, 3);
    feed(8'd99, 1'b0);
    drain();
    write_reg(REG_FRAME_PIXELS, 200000);
    feed(8'd5, 1'b0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 68; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 68; end
        default: begin src_idle = 25; sink_stall = 25; end
      endcase
      if (ph == 2) frame = MAX_PX;
      else if (ph == 5) frame = 1;
      else frame = $urandom_range(40, 1);
      if (ph == 6)
        set_params(frame, $urandom_range(15, 1), $urandom_range(255), $urandom_range(255));
      else
        set_params(frame, $urandom_range(15, 1), $urandom_range(30), $urandom_range(255, 180));
      base = $urandom_range(255);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 10) base = $urandom_range(255);
        feed(($urandom_range(99) < 70) ? near(base) : pix_t'($urandom_range(255)),
             $urandom_range(99) < 5);
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
